// ===== design/imu_complementary_tilt_filter_core_defines.svh =====
// ============================================================================
// Assertion macros for the tilt filter core
// Shared forms for concurrent checks clocked on clk and disabled in reset.
// ============================================================================
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_CORE_DEFINES_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICTF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ictf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ICTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ictf: next-cycle check failed");

`endif

// ===== design/ictf_pkg.sv =====
// ============================================================================
// ictf_pkg
// Widths, constants, types and helper functions of the tilt filter core.
// ============================================================================
package ictf_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int SAMPLE_BITS       = 16;
  localparam int TABLE_LEN         = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < TABLE_LEN) ?
                                     CORDIC_ITERATIONS : TABLE_LEN;
  localparam int CNT_W             = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int TAB_IDX_W         = $clog2(TABLE_LEN);

  // CORDIC operands are scaled so that they always occupy about 40 bits.
  localparam int SCALE_SH = 40 - SAMPLE_BITS;
  localparam int XW       = 43;
  localparam int ZW       = 26;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [ZW:0]   DEG270 = (ZW + 1)'(270 * 65536);

  localparam int IN_W      = 16;
  localparam int STEP_W    = 24;
  localparam int COEFF_W   = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int ANG_W     = 32;
  localparam int ACCX_W    = 25;
  localparam int ACCY_W    = 26;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int GPROD_W = 42;
  localparam int INC_W   = GPROD_W - 8;
  localparam int SAT_W   = 36;

  localparam int IN_DATA_W  = 6 * IN_W;
  localparam int OUT_FLD_W  = 5 * ANG_W + ACCX_W + ACCY_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

  localparam logic [STEP_W-1:0]  GYRO_STEP_RESET    = STEP_W'(23488);
  localparam logic [COEFF_W-1:0] FILTER_COEFF_RESET = COEFF_W'(63570);

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GX,
    S_GY,
    S_GZ,
    S_INCZ,
    S_WAIT_X,
    S_WAIT_Y,
    S_FX1,
    S_FX2,
    S_FXY,
    S_FY2,
    S_FY3,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                          start;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] x;
  } cordic_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic signed [ZW-1:0] angle;
  } cordic_rsp_t;

  // atan(2^-i) in degrees, Q16.16, rounded.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [TAB_IDX_W-1:0] i);
    case (i)
      5'd0:    atan_entry = ZW'(2949120);
      5'd1:    atan_entry = ZW'(1740967);
      5'd2:    atan_entry = ZW'(919879);
      5'd3:    atan_entry = ZW'(466945);
      5'd4:    atan_entry = ZW'(234379);
      5'd5:    atan_entry = ZW'(117304);
      5'd6:    atan_entry = ZW'(58666);
      5'd7:    atan_entry = ZW'(29335);
      5'd8:    atan_entry = ZW'(14668);
      5'd9:    atan_entry = ZW'(7334);
      5'd10:   atan_entry = ZW'(3667);
      5'd11:   atan_entry = ZW'(1833);
      5'd12:   atan_entry = ZW'(917);
      5'd13:   atan_entry = ZW'(458);
      5'd14:   atan_entry = ZW'(229);
      5'd15:   atan_entry = ZW'(115);
      5'd16:   atan_entry = ZW'(57);
      5'd17:   atan_entry = ZW'(29);
      5'd18:   atan_entry = ZW'(14);
      5'd19:   atan_entry = ZW'(7);
      5'd20:   atan_entry = ZW'(4);
      5'd21:   atan_entry = ZW'(2);
      5'd22:   atan_entry = ZW'(1);
      default: atan_entry = '0;
    endcase
  endfunction

  function automatic logic signed [ANG_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] vmax;
    logic signed [SAT_W-1:0] vmin;
    vmax = {{(SAT_W - ANG_W + 1){1'b0}}, {(ANG_W - 1){1'b1}}};
    vmin = {{(SAT_W - ANG_W + 1){1'b1}}, {(ANG_W - 1){1'b0}}};
    if (v > vmax) begin
      sat32 = vmax[ANG_W-1:0];
    end else if (v < vmin) begin
      sat32 = vmin[ANG_W-1:0];
    end else begin
      sat32 = v[ANG_W-1:0];
    end
  endfunction

  // Q0.24 step times raw rate, rounded half up to Q16.16.
  function automatic logic signed [INC_W-1:0] round_inc(input logic signed [PROD_W-1:0] p);
    logic signed [GPROD_W-1:0] r;
    r = p[GPROD_W-1:0] + GPROD_W'(128);
    round_inc = r[GPROD_W-1:8];
  endfunction

endpackage

// ===== design/ictf_cordic.sv =====
// ============================================================================
// ictf_cordic
// Iterative vectoring CORDIC that returns atan2(y, x) in Q16.16 degrees.
// ============================================================================
module ictf_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  ictf_pkg::cordic_req_t req,
  output ictf_pkg::cordic_rsp_t rsp
);

  logic                                busy;
  logic                                done;
  logic                                zero;
  logic [ictf_pkg::CNT_W-1:0]          cnt;
  logic signed [ictf_pkg::XW-1:0]      x;
  logic signed [ictf_pkg::XW-1:0]      y;
  logic signed [ictf_pkg::ZW-1:0]      z;
  logic signed [ictf_pkg::ZW-1:0]      angle;

  logic signed [ictf_pkg::XW-1:0]      xs;
  logic signed [ictf_pkg::XW-1:0]      ys;
  logic signed [ictf_pkg::XW-1:0]      x_load;
  logic signed [ictf_pkg::XW-1:0]      y_load;
  logic signed [ictf_pkg::ZW-1:0]      z_load;
  logic signed [ictf_pkg::XW-1:0]      dx;
  logic signed [ictf_pkg::XW-1:0]      dy;
  logic signed [ictf_pkg::XW-1:0]      x_next;
  logic signed [ictf_pkg::XW-1:0]      y_next;
  logic signed [ictf_pkg::ZW-1:0]      z_next;
  logic signed [ictf_pkg::ZW-1:0]      z_clamp;
  logic signed [ictf_pkg::ZW-1:0]      tab;
  logic                                load;
  logic                                last;

  assign load = req.start && !busy;
  assign last = (cnt == ictf_pkg::CNT_W'(ictf_pkg::CORDIC_STEPS - 1));

  // Scale and fold a negative x into the right half plane.
  always_comb begin
    xs = {{(ictf_pkg::XW - ictf_pkg::SAMPLE_BITS){req.x[ictf_pkg::SAMPLE_BITS-1]}}, req.x}
         <<< ictf_pkg::SCALE_SH;
    ys = {{(ictf_pkg::XW - ictf_pkg::SAMPLE_BITS){req.y[ictf_pkg::SAMPLE_BITS-1]}}, req.y}
         <<< ictf_pkg::SCALE_SH;
    if (xs < 0) begin
      if (ys >= 0) begin
        x_load = ys;
        y_load = -xs;
        z_load = ictf_pkg::DEG90;
      end else begin
        x_load = -ys;
        y_load = xs;
        z_load = -ictf_pkg::DEG90;
      end
    end else begin
      x_load = xs;
      y_load = ys;
      z_load = '0;
    end
  end

  // One micro-rotation per cycle through the shared shifter and adders.
  always_comb begin
    tab = ictf_pkg::atan_entry(ictf_pkg::TAB_IDX_W'(cnt));
    dx  = y >>> cnt;
    dy  = x >>> cnt;
    if (y >= 0) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + tab;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - tab;
    end
    if (z_next > ictf_pkg::DEG180) begin
      z_clamp = ictf_pkg::DEG180;
    end else if (z_next < -ictf_pkg::DEG180) begin
      z_clamp = -ictf_pkg::DEG180;
    end else begin
      z_clamp = z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x    <= x_load;
      y    <= y_load;
      z    <= z_load;
      zero <= (req.x == '0) && (req.y == '0);
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      if (last) begin
        angle <= zero ? '0 : z_clamp;
      end
    end
  end

  assign rsp.busy  = busy;
  assign rsp.done  = done;
  assign rsp.angle = angle;

endmodule

// ===== design/imu_complementary_tilt_filter_core.sv =====
// ============================================================================
// imu_complementary_tilt_filter_core
// Gyro integration and complementary tilt filter over one shared multiplier
// and one shared iterative CORDIC atan2 unit.
// ============================================================================
// Each item passes through the gyro products, two passes through the 16-step
// CORDIC atan2 unit, the blend products and the output register.
// Input ready is high only when idle, so no new item is taken while one is in work.
// A result still waiting in the output register holds the core before idle.
// Reset (rst, synchronous): clears the integrated and filtered angles, the
// handshake state and restores gyro_step and filter_coeff to their defaults.
`include "imu_complementary_tilt_filter_core_defines.svh"

module imu_complementary_tilt_filter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // Fields from bit 0: gyro_x, gyro_y, gyro_z, acc_x, acc_y, acc_z.
  input  logic [ictf_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0: gyro_angle_x, gyro_angle_y, gyro_angle_z, accel_angle_x,
  // accel_angle_y, filtered_angle_x, filtered_angle_y, zero pad.
  output logic [ictf_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_we,
  input  logic [ictf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ictf_pkg::CFG_W-1:0]             cfg_data
);

  localparam int IW = ictf_pkg::IN_W;
  localparam int AW = ictf_pkg::ANG_W;

  ictf_pkg::state_t state;
  ictf_pkg::state_t state_next;

  logic [ictf_pkg::STEP_W-1:0]           gyro_step;
  logic [ictf_pkg::COEFF_W-1:0]          filter_coeff;

  logic signed [IW-1:0]                  gx, gy, gz, ax, ay, az;
  logic signed [ictf_pkg::INC_W-1:0]     incx, incy;
  logic signed [AW-1:0]                  sum_x, sum_y, sum_z;
  logic signed [AW-1:0]                  blend_x, blend_y;
  logic signed [ictf_pkg::ACCX_W-1:0]    accx;
  logic signed [ictf_pkg::ACCY_W-1:0]    accy;
  logic signed [ictf_pkg::PROD_W-1:0]    prod;
  logic signed [ictf_pkg::PROD_W-1:0]    keep;
  logic [ictf_pkg::OUT_DATA_W-1:0]       out_data;
  logic                                  out_valid;

  logic signed [ictf_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [ictf_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [ictf_pkg::INC_W-1:0]     inc_now;
  logic signed [ictf_pkg::PROD_W-1:0]    p_sum;
  logic signed [AW-1:0]                  blend_now;
  logic signed [ictf_pkg::ZW:0]          accy_wide;
  logic [ictf_pkg::COEFF_W:0]            coeff_rest;
  logic                                  s_accept;
  logic                                  out_free;

  ictf_pkg::cordic_req_t                 cord_req;
  ictf_pkg::cordic_rsp_t                 cord_rsp;

  ictf_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cord_req),
    .rsp (cord_rsp)
  );

  assign s_axis_tready = (state == ictf_pkg::S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_step    <= ictf_pkg::GYRO_STEP_RESET;
      filter_coeff <= ictf_pkg::FILTER_COEFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ictf_pkg::REG_GYRO_STEP:    gyro_step    <= cfg_data[ictf_pkg::STEP_W-1:0];
        ictf_pkg::REG_FILTER_COEFF: filter_coeff <= cfg_data[ictf_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ictf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier operand selection and CORDIC requests.
  always_comb begin
    state_next     = state;
    mul_a          = '0;
    mul_b          = '0;
    cord_req.start = 1'b0;
    cord_req.y     = ay;
    cord_req.x     = az;
    coeff_rest     = (ictf_pkg::COEFF_W + 1)'(65536) - {1'b0, filter_coeff};
    case (state)
      ictf_pkg::S_IDLE: begin
        if (s_accept) begin
          state_next = ictf_pkg::S_GX;
        end
      end
      ictf_pkg::S_GX: begin
        mul_a      = {{(ictf_pkg::MUL_A_W - IW){gx[IW-1]}}, gx};
        mul_b      = {1'b0, gyro_step};
        state_next = ictf_pkg::S_GY;
      end
      ictf_pkg::S_GY: begin
        mul_a      = {{(ictf_pkg::MUL_A_W - IW){gy[IW-1]}}, gy};
        mul_b      = {1'b0, gyro_step};
        state_next = ictf_pkg::S_GZ;
      end
      ictf_pkg::S_GZ: begin
        mul_a      = {{(ictf_pkg::MUL_A_W - IW){gz[IW-1]}}, gz};
        mul_b      = {1'b0, gyro_step};
        state_next = ictf_pkg::S_INCZ;
      end
      ictf_pkg::S_INCZ: begin
        cord_req.start = 1'b1;
        state_next     = ictf_pkg::S_WAIT_X;
      end
      ictf_pkg::S_WAIT_X: begin
        // The second angle is atan2(acc_z, acc_x).
        cord_req.y = az;
        cord_req.x = ax;
        if (cord_rsp.done) begin
          cord_req.start = 1'b1;
          state_next     = ictf_pkg::S_WAIT_Y;
        end
      end
      ictf_pkg::S_WAIT_Y: begin
        if (cord_rsp.done) begin
          state_next = ictf_pkg::S_FX1;
        end
      end
      ictf_pkg::S_FX1: begin
        mul_a      = {{(ictf_pkg::MUL_A_W - AW){blend_x[AW-1]}}, blend_x} + incx;
        mul_b      = {{(ictf_pkg::MUL_B_W - ictf_pkg::COEFF_W){1'b0}}, filter_coeff};
        state_next = ictf_pkg::S_FX2;
      end
      ictf_pkg::S_FX2: begin
        mul_a      = {{(ictf_pkg::MUL_A_W - ictf_pkg::ACCX_W){accx[ictf_pkg::ACCX_W-1]}},
                      accx};
        mul_b      = {{(ictf_pkg::MUL_B_W - ictf_pkg::COEFF_W - 1){1'b0}}, coeff_rest};
        state_next = ictf_pkg::S_FXY;
      end
      ictf_pkg::S_FXY: begin
        mul_a      = {{(ictf_pkg::MUL_A_W - AW){blend_y[AW-1]}}, blend_y} + incy;
        mul_b      = {{(ictf_pkg::MUL_B_W - ictf_pkg::COEFF_W){1'b0}}, filter_coeff};
        state_next = ictf_pkg::S_FY2;
      end
      ictf_pkg::S_FY2: begin
        mul_a      = {{(ictf_pkg::MUL_A_W - ictf_pkg::ACCY_W){accy[ictf_pkg::ACCY_W-1]}},
                      accy};
        mul_b      = {{(ictf_pkg::MUL_B_W - ictf_pkg::COEFF_W - 1){1'b0}}, coeff_rest};
        state_next = ictf_pkg::S_FY3;
      end
      ictf_pkg::S_FY3: begin
        state_next = ictf_pkg::S_OUT;
      end
      ictf_pkg::S_OUT: begin
        if (out_free) begin
          state_next = ictf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ictf_pkg::S_IDLE;
      end
    endcase
  end

  // The registered product is consumed in the state after the one that formed it.
  always_comb begin
    inc_now   = ictf_pkg::round_inc(prod);
    p_sum     = keep + prod + ictf_pkg::PROD_W'(32768);
    blend_now = ictf_pkg::sat32(p_sum[ictf_pkg::SAT_W+15:16]);
    if (cord_rsp.angle > -ictf_pkg::DEG90) begin
      accy_wide = {cord_rsp.angle[ictf_pkg::ZW-1], cord_rsp.angle}
                  - {ictf_pkg::DEG90[ictf_pkg::ZW-1], ictf_pkg::DEG90};
    end else begin
      accy_wide = {cord_rsp.angle[ictf_pkg::ZW-1], cord_rsp.angle} + ictf_pkg::DEG270;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (s_accept) begin
      gx <= s_axis_tdata[IW-1:0];
      gy <= s_axis_tdata[2*IW-1:IW];
      gz <= s_axis_tdata[3*IW-1:2*IW];
      ax <= s_axis_tdata[4*IW-1:3*IW];
      ay <= s_axis_tdata[5*IW-1:4*IW];
      az <= s_axis_tdata[6*IW-1:5*IW];
    end
    case (state)
      ictf_pkg::S_WAIT_X: begin
        if (cord_rsp.done) begin
          accx <= cord_rsp.angle[ictf_pkg::ACCX_W-1:0];
        end
      end
      ictf_pkg::S_WAIT_Y: begin
        if (cord_rsp.done) begin
          accy <= accy_wide[ictf_pkg::ACCY_W-1:0];
        end
      end
      ictf_pkg::S_FX2: keep <= prod;
      ictf_pkg::S_FY2: keep <= prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x   <= '0;
      sum_y   <= '0;
      sum_z   <= '0;
      blend_x <= '0;
      blend_y <= '0;
    end else begin
      case (state)
        ictf_pkg::S_GY: begin
          incx  <= inc_now;
          sum_x <= ictf_pkg::sat32({{(ictf_pkg::SAT_W - AW){sum_x[AW-1]}}, sum_x}
                   + {{(ictf_pkg::SAT_W - ictf_pkg::INC_W){inc_now[ictf_pkg::INC_W-1]}},
                      inc_now});
        end
        ictf_pkg::S_GZ: begin
          incy  <= inc_now;
          sum_y <= ictf_pkg::sat32({{(ictf_pkg::SAT_W - AW){sum_y[AW-1]}}, sum_y}
                   + {{(ictf_pkg::SAT_W - ictf_pkg::INC_W){inc_now[ictf_pkg::INC_W-1]}},
                      inc_now});
        end
        ictf_pkg::S_INCZ: begin
          sum_z <= ictf_pkg::sat32({{(ictf_pkg::SAT_W - AW){sum_z[AW-1]}}, sum_z}
                   + {{(ictf_pkg::SAT_W - ictf_pkg::INC_W){inc_now[ictf_pkg::INC_W-1]}},
                      inc_now});
        end
        ictf_pkg::S_FXY: blend_x <= blend_now;
        ictf_pkg::S_FY3: blend_y <= blend_now;
        default: ;
      endcase
    end
  end

  // Output register: holds one finished item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ictf_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ictf_pkg::S_OUT && out_free) begin
      out_data <= {{ictf_pkg::OUT_PAD_W{1'b0}}, blend_y, blend_x, accy, accx,
                   sum_z, sum_y, sum_x};
    end
  end

  `ICTF_ASSERT_NOW(a_cordic_start_idle, cord_req.start, !cord_rsp.busy)
  `ICTF_ASSERT_NOW(a_cordic_done_waiting, cord_rsp.done,
                   (state == ictf_pkg::S_WAIT_X) || (state == ictf_pkg::S_WAIT_Y))
  `ICTF_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_axis_tready)

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Tilt filter core testbench
// Streams IMU samples through the core under several gyro step and filter
// weight settings. A scoreboard tracks the integrated gyro angles, the CORDIC
// accelerometer tilts and the blended angles, and checks every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import ictf_pkg::*;

  localparam longint DEG_Q16   = 65536;
  localparam longint ANGLE_MAX = 64'sd2147483647;
  localparam longint ANGLE_MIN = -64'sd2147483648;

  // Arctangent of 2^-i in degrees, Q16.16, rounded to nearest.
  localparam longint ARCTAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [IN_W-1:0] acc_z, acc_y, acc_x, gyro_z, gyro_y, gyro_x;
  } imu_sample_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0]     pad;
    logic signed [ANG_W-1:0]  filtered_y;
    logic signed [ANG_W-1:0]  filtered_x;
    logic signed [ACCY_W-1:0] accel_y;
    logic signed [ACCX_W-1:0] accel_x;
    logic signed [ANG_W-1:0]  gyro_z, gyro_y, gyro_x;
  } tilt_result_t;

  class tilt_tracker;
    longint sum_x, sum_y, sum_z, blend_x, blend_y;
    longint step_q24, coeff_q16;
    tilt_result_t expected_angles[$];
    int errors, checked, settings, sat_hits;

    function new();
      sum_x = 0; sum_y = 0; sum_z = 0; blend_x = 0; blend_y = 0;
      step_q24  = GYRO_STEP_RESET;
      coeff_q16 = FILTER_COEFF_RESET;
      errors = 0; checked = 0; settings = 0; sat_hits = 0;
    endfunction

    function void set_config(logic [CFG_W-1:0] step_data, logic [CFG_W-1:0] coeff_data);
      step_q24  = step_data;
      coeff_q16 = coeff_data[COEFF_W-1:0];
      settings++;
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction

    function longint clamp32(longint v);
      if (v > ANGLE_MAX) begin
        sat_hits++;
        return ANGLE_MAX;
      end
      if (v < ANGLE_MIN) begin
        sat_hits++;
        return ANGLE_MIN;
      end
      return v;
    endfunction

    // Vectoring CORDIC; a left half-plane vector is first turned by 90 degrees.
    function longint atan2_q16(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x <<< SCALE_SH;
      y = y <<< SCALE_SH;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 90 * DEG_Q16;
        end else begin
          t = x; x = -y; y = t; z = -90 * DEG_Q16;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ARCTAN_Q16[i];
        end else begin
          x -= dx; y += dy; z -= ARCTAN_Q16[i];
        end
      end
      if (z > 180 * DEG_Q16) z = 180 * DEG_Q16;
      if (z < -180 * DEG_Q16) z = -180 * DEG_Q16;
      return z;
    endfunction

    function longint blend_step(longint prev, longint inc, longint tilt);
      longint p;
      p = (prev + inc) * coeff_q16 + tilt * (65536 - coeff_q16) + 32768;
      return clamp32(p >>> 16);
    endfunction

    function void add_sample(imu_sample_t s);
      longint inc_x, inc_y, inc_z, tilt_x, tilt_y, t;
      tilt_result_t r;
      inc_x = (longint'(s.gyro_x) * step_q24 + 128) >>> 8;
      inc_y = (longint'(s.gyro_y) * step_q24 + 128) >>> 8;
      inc_z = (longint'(s.gyro_z) * step_q24 + 128) >>> 8;
      sum_x = clamp32(sum_x + inc_x);
      sum_y = clamp32(sum_y + inc_y);
      sum_z = clamp32(sum_z + inc_z);
      tilt_x = atan2_q16(s.acc_y, s.acc_z);
      t = atan2_q16(s.acc_z, s.acc_x);
      tilt_y = (t + 180 * DEG_Q16 > 90 * DEG_Q16) ? t - 90 * DEG_Q16 : t + 270 * DEG_Q16;
      blend_x = blend_step(blend_x, inc_x, tilt_x);
      blend_y = blend_step(blend_y, inc_y, tilt_y);
      r = '0;
      r.gyro_x     = sum_x[ANG_W-1:0];
      r.gyro_y     = sum_y[ANG_W-1:0];
      r.gyro_z     = sum_z[ANG_W-1:0];
      r.accel_x    = tilt_x[ACCX_W-1:0];
      r.accel_y    = tilt_y[ACCY_W-1:0];
      r.filtered_x = blend_x[ANG_W-1:0];
      r.filtered_y = blend_y[ANG_W-1:0];
      expected_angles.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tilt_result_t got);
      tilt_result_t want;
      if (expected_angles.size() == 0) begin
        $error("Result item arrived with no sample outstanding");
        errors++;
        return;
      end
      want = expected_angles.pop_front();
      checked++;
      compare_field("gyro_angle_x", want.gyro_x, got.gyro_x);
      compare_field("gyro_angle_y", want.gyro_y, got.gyro_y);
      compare_field("gyro_angle_z", want.gyro_z, got.gyro_z);
      compare_field("accel_angle_x", want.accel_x, got.accel_x);
      compare_field("accel_angle_y", want.accel_y, got.accel_y);
      compare_field("filtered_angle_x", want.filtered_x, got.filtered_x);
      compare_field("filtered_angle_y", want.filtered_y, got.filtered_y);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  tilt_tracker tracker = new();
  int          results_seen = 0;
  bit          calm = 1'b0;

  imu_complementary_tilt_filter_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic imu_sample_t make_sample(
    logic signed [IN_W-1:0] gx, logic signed [IN_W-1:0] gy, logic signed [IN_W-1:0] gz,
    logic signed [IN_W-1:0] ax, logic signed [IN_W-1:0] ay, logic signed [IN_W-1:0] az);
    imu_sample_t s;
    s.gyro_x = gx; s.gyro_y = gy; s.gyro_z = gz;
    s.acc_x = ax; s.acc_y = ay; s.acc_z = az;
    return s;
  endfunction

  // Mostly full-range values, with axis corners and zero mixed in.
  function automatic logic signed [IN_W-1:0] pick_axis();
    case ($urandom_range(0, 11))
      0:       return 16'sh0000;
      1:       return 16'sh7FFF;
      2:       return 16'sh8000;
      3:       return 16'shFFFF;
      4:       return 16'sh0001;
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(imu_sample_t s);
    if (!calm && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk); while (!s_axis_tready);
    tracker.add_sample(s);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Only called while the core is idle.
  task automatic apply_settings(logic [CFG_W-1:0] step_data, logic [CFG_W-1:0] coeff_data);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GYRO_STEP;
    cfg_data  <= step_data;
    @(posedge clk);
    cfg_index <= REG_FILTER_COEFF;
    cfg_data  <= coeff_data;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_config(step_data, coeff_data);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata);
      results_seen++;
    end
  end

  // Result side: short random stalls, and one long hold-off that backs the
  // core up so that it refuses input while the sender keeps offering.
  initial begin
    bit held_long;
    held_long = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (!held_long && results_seen >= 100) begin
        held_long = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    imu_sample_t batch[$];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_GYRO_STEP;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset weights: zero vectors, axis extremes and both left half-plane turns.
    batch = '{
      make_sample(0, 0, 0, 0, 0, 0),
      make_sample(32767, 32767, 32767, 0, 0, 32767),
      make_sample(-32768, -32768, -32768, -32768, -32768, -32768),
      make_sample(1, -1, 0, 32767, 32767, 32767),
      make_sample(-1, 1, 5, -32768, 100, -200),
      make_sample(100, -100, 0, -10, -100, -200),
      make_sample(0, 0, 0, 0, 0, -32768),
      make_sample(0, 0, 0, -32768, 0, 0),
      make_sample(0, 0, 0, 0, -32768, 0)
    };
    foreach (batch[i]) send_sample(batch[i]);

    // Largest step drives the integrated angles into both rails.
    drain_results();
    apply_settings(24'hFFFFFF, 24'h000000);
    batch = '{
      make_sample(32767, -32768, 1000, 300, 400, 500),
      make_sample(32767, -32768, 1000, -300, -400, 500),
      make_sample(-32768, 32767, -32768, 7, -9, -11),
      make_sample(-32768, 32767, -32768, 0, 1, -1),
      make_sample(-32768, 32767, -32768, 32767, -32768, 1),
      make_sample(0, 0, 0, 0, 0, 0)
    };
    foreach (batch[i]) send_sample(batch[i]);

    // Full gyro weight pushes the blended angles into saturation too.
    drain_results();
    apply_settings(24'hFFFFFF, 24'h00FFFF);
    batch = '{
      make_sample(32767, 32767, 32767, 1, 2, 3),
      make_sample(32767, 32767, 32767, -1, -2, -3),
      make_sample(-32768, -32768, -32768, 0, 0, 0),
      make_sample(-32768, -32768, -32768, 32767, 32767, -32768)
    };
    foreach (batch[i]) send_sample(batch[i]);

    // Zero step; the weight write carries bits above the register width.
    drain_results();
    apply_settings(24'h000000, 24'hAB8000);
    batch = '{
      make_sample(32767, -32768, 12345, 1, 1, 1),
      make_sample(-5, 5, 0, -1, -1, -1)
    };
    foreach (batch[i]) send_sample(batch[i]);

    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      case (ph)
        0: apply_settings(CFG_W'(GYRO_STEP_RESET), CFG_W'(FILTER_COEFF_RESET));
        1: apply_settings(CFG_W'($urandom), CFG_W'($urandom));
        2: apply_settings(24'hFFFFFF, CFG_W'($urandom_range(0, 65535)));
        3: apply_settings(CFG_W'($urandom_range(0, 100000)), 24'h000000);
        default: apply_settings(CFG_W'($urandom_range(0, 50000)),
                                CFG_W'($urandom_range(60000, 65535)));
      endcase
      if (ph == 4) calm = 1'b1;
      repeat (96) begin
        send_sample(make_sample(pick_axis(), pick_axis(), pick_axis(),
                                pick_axis(), pick_axis(), pick_axis()));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Checked %0d tilt results under %0d weight settings after the reset defaults.",
             tracker.checked, tracker.settings);
    $display("Angle saturation occurred %0d times; zero accel vectors and half-plane turns hit.",
             tracker.sat_hits);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", tracker.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
